// ===== rtl/lss_pkg.sv =====
// Shared types and constants for the LIFO stack with search.
package lss_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned OP_W      = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_LIST   = 3'd3,
    OP_COUNT  = 3'd4,
    OP_SEARCH = 3'd5,
    OP_CLEAR  = 3'd6
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_DOWN = 2'd1,
    CELL_UP   = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_WALK = 1'b1
  } fsm_e;

  typedef struct packed {
    cell_op_e         op;
    logic [CNT_W-1:0] tail;
  } cell_cmd_t;

endpackage

// ===== rtl/lifo_stack_with_search.sv =====
// Top level of the LIFO stack with search: cell chain, sequencer and output register.
// The stack is a chain of DEPTH cells with the top word in cell 0. A push shifts the
// chain down by one place and a pop shifts it up; push, pop, peek, count and clear
// each give one result word, and a new word can be accepted as soon as the output
// register is free. List and search walk the stack by turning the occupied cells
// round one place per cycle while the output register is free, and looking at cell
// 0; after one full turn the order is as before. A list gives one result word per
// held entry, each being given out as it is read, and a search gives its single
// result word at the end of the turn. The walk stalls only while the output register
// holds a word that has not been taken. No input word is taken during a walk. The
// operation code travels in s_axis_tuser_i; operation code seven is taken and
// dropped without a result.
module lifo_stack_with_search #(
  parameter int unsigned DEPTH = lss_pkg::DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [1:0] status, [33:2] data, [40:34] position,
                                        // [47:41] count
  output logic        m_axis_tlast_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned DW = lss_pkg::DATA_W;
  localparam int unsigned PW = lss_pkg::CNT_W;

  // Sequencer state.
  lss_pkg::fsm_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] walk_q, walk_d;
  logic          list_q, list_d;
  logic          found_q, found_d;
  logic [CW-1:0] fpos_q, fpos_d;
  logic [DW-1:0] value_q, value_d;

  // Output register.
  logic                   out_valid_q, out_valid_d;
  lss_pkg::status_e       out_status_q, out_status_d;
  logic [DW-1:0]          out_data_q, out_data_d;
  logic [PW-1:0]          out_pos_q, out_pos_d;
  logic [PW-1:0]          out_count_q, out_count_d;
  logic                   out_last_q, out_last_d;

  lss_pkg::cell_cmd_t     cmd;
  logic [DW-1:0]          cell_data [DEPTH];

  logic slot_free;
  logic s_fire;
  logic is_full;
  logic is_empty;
  logic walk_end;
  logic hit;
  logic [CW-1:0] tail;

  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == lss_pkg::FSM_IDLE) && slot_free;
  assign s_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign is_full   = (count_q == CW'(DEPTH));
  assign is_empty  = (count_q == '0);
  assign tail      = count_q - 1'b1;
  assign walk_end  = (walk_q == tail);
  assign hit       = (cell_data[0] == value_q);

  // The chain of cells. The pushed word enters at the top; a zero word enters at the
  // bottom on a pop, and the top word wraps round to the tail while walking.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DW-1:0] upper;
    logic [DW-1:0] lower;
    if (g == 0) begin : g_top
      assign upper = s_axis_tdata_i;
    end else begin : g_mid_up
      assign upper = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_bottom
      assign lower = '0;
    end else begin : g_mid_low
      assign lower = cell_data[g+1];
    end
    lss_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .upper_i(upper),
      .lower_i(lower),
      .wrap_i (cell_data[0]),
      .data_o (cell_data[g])
    );
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    walk_d       = walk_q;
    list_d       = list_q;
    found_d      = found_q;
    fpos_d       = fpos_q;
    value_d      = value_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_pos_d    = out_pos_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;
    cmd.op       = lss_pkg::CELL_HOLD;
    cmd.tail     = PW'(tail);

    case (state_q)
      lss_pkg::FSM_IDLE: begin
        if (s_fire) begin
          // Defaults for a single result word of an ordinary operation.
          out_status_d = lss_pkg::ST_OK;
          out_data_d   = '0;
          out_pos_d    = '0;
          out_count_d  = PW'(count_q);
          out_last_d   = 1'b1;
          out_valid_d  = 1'b1;
          case (s_axis_tuser_i)
            lss_pkg::OP_PUSH: begin
              if (is_full) begin
                out_status_d = lss_pkg::ST_FULL;
              end else begin
                cmd.op      = lss_pkg::CELL_DOWN;
                count_d     = count_q + 1'b1;
                out_count_d = PW'(count_d);
              end
            end
            lss_pkg::OP_POP: begin
              if (is_empty) begin
                out_status_d = lss_pkg::ST_EMPTY;
              end else begin
                cmd.op      = lss_pkg::CELL_UP;
                count_d     = tail;
                out_data_d  = cell_data[0];
                out_count_d = PW'(count_d);
              end
            end
            lss_pkg::OP_PEEK: begin
              if (is_empty) begin
                out_status_d = lss_pkg::ST_EMPTY;
              end else begin
                out_data_d = cell_data[0];
              end
            end
            lss_pkg::OP_LIST, lss_pkg::OP_SEARCH: begin
              if (is_empty) begin
                out_status_d = lss_pkg::ST_EMPTY;
              end else begin
                // The walk gives its own result words.
                out_valid_d = 1'b0;
                state_d     = lss_pkg::FSM_WALK;
                walk_d      = '0;
                list_d      = (s_axis_tuser_i == lss_pkg::OP_LIST);
                found_d     = 1'b0;
                value_d     = s_axis_tdata_i;
              end
            end
            lss_pkg::OP_COUNT: begin
              out_status_d = lss_pkg::ST_OK;
            end
            lss_pkg::OP_CLEAR: begin
              if (is_empty) begin
                out_status_d = lss_pkg::ST_EMPTY;
              end else begin
                count_d     = '0;
                out_count_d = '0;
              end
            end
            default: begin
              // Unused operation code: no result, no change.
              out_valid_d = 1'b0;
            end
          endcase
        end
      end
      lss_pkg::FSM_WALK: begin
        if (slot_free) begin
          cmd.op = lss_pkg::CELL_ROT;
          walk_d = walk_q + 1'b1;
          if (list_q) begin
            out_valid_d  = 1'b1;
            out_status_d = lss_pkg::ST_OK;
            out_data_d   = cell_data[0];
            out_pos_d    = PW'(walk_q + 1'b1);
            out_count_d  = PW'(count_q);
            out_last_d   = walk_end;
          end else begin
            if (hit && !found_q) begin
              found_d = 1'b1;
              fpos_d  = walk_q + 1'b1;
            end
            if (walk_end) begin
              out_valid_d = 1'b1;
              out_data_d  = '0;
              out_count_d = PW'(count_q);
              out_last_d  = 1'b1;
              if (found_q) begin
                out_status_d = lss_pkg::ST_OK;
                out_pos_d    = PW'(fpos_q);
              end else if (hit) begin
                out_status_d = lss_pkg::ST_OK;
                out_pos_d    = PW'(walk_q + 1'b1);
              end else begin
                out_status_d = lss_pkg::ST_NOT_FOUND;
                out_pos_d    = '0;
              end
            end
          end
          if (walk_end) begin
            state_d = lss_pkg::FSM_IDLE;
          end
        end
      end
      default: state_d = lss_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lss_pkg::FSM_IDLE;
      count_q     <= '0;
      walk_q      <= '0;
      list_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      walk_q      <= walk_d;
      list_q      <= list_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fpos_q       <= fpos_d;
    value_q      <= value_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_pos_q    <= out_pos_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_count_q, out_pos_q, out_data_q, out_status_q};
  assign m_axis_tlast_o  = out_last_q;

  // A walk is only ever started on a stack that holds something.
  a_walk_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lss_pkg::FSM_WALK) |-> (count_q != '0))
    else $error("walk running on an empty stack");

  // The walk index stays inside the occupied cells.
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lss_pkg::FSM_WALK) |-> (walk_q < count_q))
    else $error("walk index beyond the fill level");

  // The fill level never exceeds the chain length.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill level beyond depth");

  // An accepted push onto a stack with room raises the fill level by one.
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (s_axis_tuser_i == lss_pkg::OP_PUSH) && !is_full)
      |=> (count_q == $past(count_q) + 1'b1))
    else $error("push did not raise the fill level");

endmodule

// ===== rtl/lss_cell.sv =====
// One storage cell of the stack chain; cell 0 holds the top word.
module lss_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                          clk_i,
  input  lss_pkg::cell_cmd_t            cmd_i,
  input  logic [lss_pkg::DATA_W-1:0]    upper_i,
  input  logic [lss_pkg::DATA_W-1:0]    lower_i,
  input  logic [lss_pkg::DATA_W-1:0]    wrap_i,
  output logic [lss_pkg::DATA_W-1:0]    data_o
);

  logic [lss_pkg::DATA_W-1:0] data_q, data_d;
  logic [lss_pkg::CNT_W-1:0]  my_idx;

  assign my_idx = lss_pkg::CNT_W'(IDX);

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      lss_pkg::CELL_DOWN: data_d = upper_i;
      lss_pkg::CELL_UP:   data_d = lower_i;
      lss_pkg::CELL_ROT: begin
        // The occupied part turns by one place: the top word moves to the tail.
        if (my_idx == cmd_i.tail) begin
          data_d = wrap_i;
        end else if (my_idx < cmd_i.tail) begin
          data_d = lower_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== bench/tb_lifo_stack_with_search.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the LIFO stack with search: queued stimulus, predictor, checker.
module tb_lifo_stack_with_search;

  localparam int unsigned STACK_DEPTH      = lss_pkg::DEPTH_DEF;
  localparam logic [lss_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int unsigned WATCHDOG_LIMIT   = 4000;
  localparam int unsigned SINK_HOLD_CYCLES = 300;
  // A search of a full stack walks every entry before its result word appears.
  localparam int unsigned DRAIN_CYCLES     = STACK_DEPTH + 16;

  typedef struct {
    logic [lss_pkg::OP_W-1:0]   op;
    logic [lss_pkg::DATA_W-1:0] value;
  } stack_cmd_t;

  typedef struct {
    lss_pkg::status_e           status;
    logic [lss_pkg::DATA_W-1:0] data;
    logic [lss_pkg::CNT_W-1:0]  position;
    logic [lss_pkg::CNT_W-1:0]  count;
    logic                       last;
  } stack_result_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i  = '0;   // [31:0] value
  logic [2:0]  s_axis_tuser_i  = '0;   // [2:0] op
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;         // [1:0] status, [33:2] data, [40:34] position,
                                       // [47:41] count
  logic        m_axis_tlast_o;

  // Our own picture of the stack, with the bottom word at index 0.
  logic [lss_pkg::DATA_W-1:0] stack_image [STACK_DEPTH];
  int                         stack_fill = 0;

  stack_cmd_t                 pending_cmds[$];
  stack_result_t              expected_results[$];
  logic [lss_pkg::DATA_W-1:0] recent_pushes[$];

  int unsigned src_idle_pct   = 15;
  int unsigned sink_idle_pct  = 77;
  int unsigned hold_requests  = 0;
  int unsigned hold_served    = 0;
  int unsigned sink_hold_left = 0;
  int unsigned stall_cycles   = 0;
  int unsigned words_in       = 0;
  int unsigned words_out      = 0;
  int unsigned deepest_fill   = 0;
  int unsigned errors         = 0;
  logic [7:0]  ops_seen       = '0;

  lifo_stack_with_search u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Records one expected result word; the count is the fill level after the operation.
  function automatic void add_result(lss_pkg::status_e status,
                                     logic [lss_pkg::DATA_W-1:0] data,
                                     logic [lss_pkg::CNT_W-1:0] position, logic last);
    stack_result_t r;
    r.status   = status;
    r.data     = data;
    r.position = position;
    r.count    = lss_pkg::CNT_W'(stack_fill);
    r.last     = last;
    expected_results.push_back(r);
  endfunction

  // Applies one accepted word to the stack picture and queues the words it causes.
  function automatic void predict_stack_op(logic [lss_pkg::OP_W-1:0] op,
                                           logic [lss_pkg::DATA_W-1:0] value);
    int hit;
    hit = 0;
    case (op)
      lss_pkg::OP_PUSH: begin
        if (stack_fill == STACK_DEPTH) begin
          add_result(lss_pkg::ST_FULL, '0, '0, 1'b1);
        end else begin
          stack_image[stack_fill] = value;
          stack_fill++;
          add_result(lss_pkg::ST_OK, '0, '0, 1'b1);
        end
      end
      lss_pkg::OP_POP: begin
        if (stack_fill == 0) begin
          add_result(lss_pkg::ST_EMPTY, '0, '0, 1'b1);
        end else begin
          stack_fill--;
          add_result(lss_pkg::ST_OK, stack_image[stack_fill], '0, 1'b1);
        end
      end
      lss_pkg::OP_PEEK: begin
        if (stack_fill == 0) add_result(lss_pkg::ST_EMPTY, '0, '0, 1'b1);
        else add_result(lss_pkg::ST_OK, stack_image[stack_fill-1], '0, 1'b1);
      end
      lss_pkg::OP_LIST: begin
        if (stack_fill == 0) begin
          add_result(lss_pkg::ST_EMPTY, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < stack_fill; i++)
            add_result(lss_pkg::ST_OK, stack_image[stack_fill-1-i],
                       lss_pkg::CNT_W'(i+1), i + 1 == stack_fill);
        end
      end
      lss_pkg::OP_COUNT: add_result(lss_pkg::ST_OK, '0, '0, 1'b1);
      lss_pkg::OP_SEARCH: begin
        if (stack_fill == 0) begin
          add_result(lss_pkg::ST_EMPTY, '0, '0, 1'b1);
        end else begin
          // The match nearest the top wins.
          for (int i = 0; i < stack_fill && hit == 0; i++)
            if (stack_image[stack_fill-1-i] == value) hit = i + 1;
          if (hit != 0) add_result(lss_pkg::ST_OK, '0, lss_pkg::CNT_W'(hit), 1'b1);
          else add_result(lss_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
        end
      end
      lss_pkg::OP_CLEAR: begin
        if (stack_fill == 0) begin
          add_result(lss_pkg::ST_EMPTY, '0, '0, 1'b1);
        end else begin
          stack_fill = 0;
          add_result(lss_pkg::ST_OK, '0, '0, 1'b1);
        end
      end
      default: ;  // the unused code is swallowed without a result
    endcase
    if (stack_fill > deepest_fill) deepest_fill = stack_fill;
  endfunction

  function automatic void queue_cmd(logic [lss_pkg::OP_W-1:0] op,
                                    logic [lss_pkg::DATA_W-1:0] value);
    stack_cmd_t c;
    c.op    = op;
    c.value = value;
    pending_cmds.push_back(c);
  endfunction

  // Mostly full-range words, with the sign extremes and small values mixed in.
  function automatic logic [lss_pkg::DATA_W-1:0] random_word();
    int unsigned pick;
    pick = $urandom_range(4);
    if (pick == 0) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return '0;
        default: return '1;
      endcase
    end
    if (pick == 1) return lss_pkg::DATA_W'($urandom_range(15));
    return $urandom();
  endfunction

  // Random operations weighted towards pushes and searches, so that the stack grows and
  // most searches look for a word that was pushed recently. Dropped codes do not count.
  task automatic queue_random_cmds(int unsigned n);
    int unsigned queued;
    int unsigned pick;
    logic [lss_pkg::OP_W-1:0] op;
    logic [lss_pkg::DATA_W-1:0] value;
    queued = 0;
    while (queued < n) begin
      pick  = $urandom_range(99);
      value = random_word();
      if (pick < 48) op = lss_pkg::OP_PUSH;
      else if (pick < 60) op = lss_pkg::OP_POP;
      else if (pick < 66) op = lss_pkg::OP_PEEK;
      else if (pick < 71) op = lss_pkg::OP_LIST;
      else if (pick < 75) op = lss_pkg::OP_COUNT;
      else if (pick < 94) op = lss_pkg::OP_SEARCH;
      else if (pick < 97) op = lss_pkg::OP_CLEAR;
      else op = OP_UNUSED;
      if (op == lss_pkg::OP_SEARCH && recent_pushes.size() != 0 && $urandom_range(9) < 6)
        value = recent_pushes[$urandom_range(recent_pushes.size() - 1)];
      if (op == lss_pkg::OP_PUSH) begin
        recent_pushes.push_back(value);
        if (recent_pushes.size() > 16) recent_pushes.delete(0);
      end
      queue_cmd(op, value);
      if (op != OP_UNUSED) queued++;
    end
  endtask

  // Waits until every queued word has gone in and every expected result has come back out.
  task automatic wait_for_drain();
    while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Driver: offers the head of the pending queue, holding each word until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_stack_op(s_axis_tuser_i, s_axis_tdata_i);
        ops_seen[s_axis_tuser_i] = 1'b1;
        words_in++;
        pending_cmds.delete(0);
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= pending_cmds[0].op;
          s_axis_tdata_i  <= pending_cmds[0].value;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word against the oldest expectation and drives tready,
  // including the long hold-off that backs the block up into its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin : monitor
      stack_result_t want;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        words_out++;
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: tdata %h last %b",
                 m_axis_tdata_o, m_axis_tlast_o);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata_o[1:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tdata_o[1:0]);
            errors++;
          end
          if (m_axis_tdata_o[33:2] !== want.data) begin
            $error("data: expected %h, got %h", want.data, m_axis_tdata_o[33:2]);
            errors++;
          end
          if (m_axis_tdata_o[40:34] !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, m_axis_tdata_o[40:34]);
            errors++;
          end
          if (m_axis_tdata_o[47:41] !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, m_axis_tdata_o[47:41]);
            errors++;
          end
          if (m_axis_tlast_o !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_axis_tlast_o);
            errors++;
          end
        end
      end
      if (hold_served != hold_requests) begin
        hold_served     <= hold_requests;
        sink_hold_left  <= SINK_HOLD_CYCLES;
        m_axis_tready_i <= 1'b0;
      end else if (sink_hold_left != 0) begin
        sink_hold_left  <= sink_hold_left - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Watchdog: a stall with no word moving on either side that reaches the watchdog limit ends the run.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [lss_pkg::DATA_W-1:0] bottom_word;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Every operation but push on an empty stack first, then the sign extremes and a duplicate.
    queue_cmd(lss_pkg::OP_CLEAR,  '0);
    queue_cmd(lss_pkg::OP_POP,    '0);
    queue_cmd(lss_pkg::OP_PEEK,   '0);
    queue_cmd(lss_pkg::OP_LIST,   '0);
    queue_cmd(lss_pkg::OP_SEARCH, '0);
    queue_cmd(lss_pkg::OP_COUNT,  '0);
    queue_cmd(lss_pkg::OP_PUSH,   32'h8000_0000);
    queue_cmd(lss_pkg::OP_PUSH,   32'h7fff_ffff);
    queue_cmd(lss_pkg::OP_PUSH,   32'h0000_0000);
    queue_cmd(lss_pkg::OP_PUSH,   32'hffff_ffff);
    queue_cmd(lss_pkg::OP_PUSH,   32'h0000_0000);
    queue_cmd(lss_pkg::OP_PEEK,   '0);
    queue_cmd(lss_pkg::OP_SEARCH, 32'h0000_0000);
    queue_cmd(lss_pkg::OP_SEARCH, 32'h8000_0000);
    queue_cmd(lss_pkg::OP_SEARCH, 32'h1234_5678);
    queue_cmd(lss_pkg::OP_LIST,   '0);
    queue_cmd(lss_pkg::OP_COUNT,  '0);
    queue_cmd(OP_UNUSED,          32'hdead_beef);
    queue_cmd(lss_pkg::OP_POP,    '0);
    queue_cmd(lss_pkg::OP_POP,    '0);
    queue_cmd(lss_pkg::OP_COUNT,  '0);
    queue_cmd(lss_pkg::OP_CLEAR,  '0);
    queue_cmd(lss_pkg::OP_COUNT,  '0);
    queue_random_cmds(45);
    wait_for_drain();

    // Second phase: the sender idles most of the time and the receiver rarely.
    src_idle_pct  <= 77;
    sink_idle_pct <= 15;
    // Fill the stack to the brim, overflow it, then search for the bottom word and list
    // the whole of it.
    bottom_word = $urandom();
    queue_cmd(lss_pkg::OP_CLEAR, '0);
    queue_cmd(lss_pkg::OP_PUSH, bottom_word);
    for (int i = 1; i < STACK_DEPTH; i++) queue_cmd(lss_pkg::OP_PUSH, $urandom());
    queue_cmd(lss_pkg::OP_PUSH,   32'h7fff_ffff);
    queue_cmd(lss_pkg::OP_SEARCH, bottom_word);
    queue_cmd(lss_pkg::OP_LIST,   '0);
    queue_cmd(lss_pkg::OP_PEEK,   '0);
    queue_cmd(lss_pkg::OP_POP,    '0);
    queue_cmd(lss_pkg::OP_PUSH,   32'h8000_0000);
    queue_cmd(lss_pkg::OP_PUSH,   32'h0000_0001);
    queue_cmd(lss_pkg::OP_COUNT,  '0);
    queue_cmd(lss_pkg::OP_CLEAR,  '0);
    queue_random_cmds(45);
    wait_for_drain();

    // Third phase: no idling on either side, opened by one long receiver hold-off while
    // the sender keeps offering words.
    src_idle_pct  <= 0;
    sink_idle_pct <= 0;
    @(posedge clk_i);
    hold_requests <= hold_requests + 1;
    queue_random_cmds(45);
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d input words (opcodes seen %b) and %0d result words checked,",
             words_in, ops_seen, words_out);
    $display("with the stack filled to %0d of %0d and a %0d-cycle receiver hold-off.",
             deepest_fill, STACK_DEPTH, SINK_HOLD_CYCLES);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lss_pkg.sv
rtl/lss_cell.sv
rtl/lifo_stack_with_search.sv
bench/tb_lifo_stack_with_search.sv
